FILE: rtl/pspp_pkg.sv
// Shared types, constants and defaults of the program stream PES packetizer.
`default_nettype none
package pspp_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 24;
  localparam int unsigned JOB_DEPTH_DEF = 2;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 22;
  localparam int unsigned MUX_RATE_W = 22;
  localparam int unsigned PTS_DELAY_W = 20;
  localparam int unsigned TIME_W = 33;
  localparam int unsigned PAYLOAD_LEN_W = 24;

  localparam logic [MUX_RATE_W-1:0] MUX_RATE_RST = 22'd2621;
  localparam logic [PTS_DELAY_W-1:0] PTS_DELAY_RST = 20'd27000;

  localparam int unsigned PES_MAX = 65535;
  localparam int unsigned PES_HDR_SHORT = 9;
  localparam int unsigned PES_HDR_LONG = 14;
  localparam int unsigned PES_LEN_OFS = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MUX_RATE  = 1'b0,
    REG_PTS_DELAY = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    HDR_NONE = 2'd0,
    HDR_PES  = 2'd1,
    HDR_PACK = 2'd2
  } hdr_e;

  typedef struct packed {
    hdr_e              hdr;
    logic              has_data;
    logic [7:0]        stream;
    logic [15:0]       len_field;
    logic [TIME_W-1:0] scr;
    logic [TIME_W-1:0] pts;
    logic [7:0]        data;
  } job_t;

endpackage
`default_nettype wire

FILE: rtl/pspp_front.sv
// Front end: accepts items, tracks packet state and turns each item into a job.
`default_nettype none
module pspp_front #(
  parameter int unsigned LENGTH_BITS = pspp_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 accept_i,
  input  wire logic                                 command_i,
  input  wire logic [7:0]                           stream_id_i,
  input  wire logic [pspp_pkg::PAYLOAD_LEN_W-1:0]   payload_length_i,
  input  wire logic                                 has_time_i,
  input  wire logic [pspp_pkg::TIME_W-1:0]          time_ticks_i,
  input  wire logic [7:0]                           payload_byte_i,
  input  wire logic [pspp_pkg::PTS_DELAY_W-1:0]     pts_delay_i,
  output pspp_pkg::job_t                            job_o,
  output logic                                      job_push_o
);

  localparam logic [LENGTH_BITS-1:0] CapLong =
      LENGTH_BITS'(pspp_pkg::PES_MAX - pspp_pkg::PES_HDR_LONG);
  localparam logic [LENGTH_BITS-1:0] CapShort =
      LENGTH_BITS'(pspp_pkg::PES_MAX - pspp_pkg::PES_HDR_SHORT);
  localparam logic [15:0] CapLongShare = 16'(pspp_pkg::PES_MAX - pspp_pkg::PES_HDR_LONG);
  localparam logic [15:0] CapShortShare = 16'(pspp_pkg::PES_MAX - pspp_pkg::PES_HDR_SHORT);
  localparam logic [15:0] CapLenField = 16'(pspp_pkg::PES_MAX - pspp_pkg::PES_LEN_OFS);
  localparam logic [15:0] AddLong = 16'(pspp_pkg::PES_HDR_LONG - pspp_pkg::PES_LEN_OFS);
  localparam logic [15:0] AddShort = 16'(pspp_pkg::PES_HDR_SHORT - pspp_pkg::PES_LEN_OFS);

  logic [LENGTH_BITS-1:0] br_q, br_d;
  logic [15:0]            pbl_q, pbl_d;
  logic [7:0]             stream_q, stream_d;

  logic [LENGTH_BITS-1:0] br_in;
  logic                   cap_long, cap_short, cap_cont;

  assign br_in     = LENGTH_BITS'(payload_length_i);
  assign cap_long  = br_in > CapLong;
  assign cap_short = br_in > CapShort;
  assign cap_cont  = br_q > CapShort;

  always_comb begin
    br_d       = br_q;
    pbl_d      = pbl_q;
    stream_d   = stream_q;
    job_push_o = 1'b0;
    job_o.hdr       = pspp_pkg::HDR_NONE;
    job_o.has_data  = 1'b0;
    job_o.stream    = stream_q;
    job_o.len_field = '0;
    job_o.scr       = time_ticks_i;
    job_o.pts       = time_ticks_i + pspp_pkg::TIME_W'(pts_delay_i);
    job_o.data      = payload_byte_i;
    if (accept_i) begin
      if (!command_i) begin
        job_push_o   = 1'b1;
        stream_d     = stream_id_i;
        br_d         = br_in;
        job_o.stream = stream_id_i;
        if (has_time_i) begin
          job_o.hdr       = pspp_pkg::HDR_PACK;
          job_o.len_field = cap_long ? CapLenField : br_in[15:0] + AddLong;
          pbl_d           = cap_long ? CapLongShare : br_in[15:0];
        end else begin
          job_o.hdr       = pspp_pkg::HDR_PES;
          job_o.len_field = cap_short ? CapLenField : br_in[15:0] + AddShort;
          pbl_d           = cap_short ? CapShortShare : br_in[15:0];
        end
      end else if (br_q != '0) begin
        job_push_o     = 1'b1;
        job_o.has_data = 1'b1;
        br_d           = br_q - LENGTH_BITS'(1);
        if (pbl_q == '0) begin
          job_o.hdr       = pspp_pkg::HDR_PES;
          job_o.len_field = cap_cont ? CapLenField : br_q[15:0] + AddShort;
          pbl_d           = (cap_cont ? CapShortShare : br_q[15:0]) - 16'd1;
        end else begin
          pbl_d = pbl_q - 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      br_q     <= '0;
      pbl_q    <= '0;
      stream_q <= '0;
    end else begin
      br_q     <= br_d;
      pbl_q    <= pbl_d;
      stream_q <= stream_d;
    end
  end

  // The share still owed to the open packet never exceeds the payload still expected.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    LENGTH_BITS'(pbl_q) <= br_q)
    else $error("packet share exceeds remaining payload");

endmodule
`default_nettype wire

FILE: rtl/pspp_job_fifo.sv
// Short job queue between the front end and the byte serializer.
`default_nettype none
module pspp_job_fifo #(
  parameter int unsigned DEPTH = pspp_pkg::JOB_DEPTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_i,
  input  wire pspp_pkg::job_t wr_job_i,
  input  wire logic           rd_i,
  output pspp_pkg::job_t      rd_job_o,
  output logic                full_o,
  output logic                valid_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  pspp_pkg::job_t        mem_q [DEPTH];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       cnt_q;

  assign full_o   = cnt_q == CntFull;
  assign valid_o  = cnt_q != '0;
  assign rd_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(wr_i && full_o))
    else $error("job queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(rd_i && !valid_o))
    else $error("job queue underflow");

endmodule
`default_nettype wire

FILE: rtl/pspp_back.sv
// Back end: expands jobs into header and payload bytes behind an output register.
`default_nettype none
module pspp_back (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire pspp_pkg::job_t                     job_i,
  input  wire logic                               job_valid_i,
  output logic                                    job_pop_o,
  input  wire logic [pspp_pkg::MUX_RATE_W-1:0]    mux_rate_i,
  input  wire logic                               pop_i,
  output logic                                    empty_o,
  output logic [7:0]                              out_byte_o,
  output logic                                    is_header_o,
  output logic                                    last_o
);

  localparam logic [4:0] PackLen = 5'd14;

  function automatic logic [7:0] pack_byte(input logic [3:0] idx,
                                           input logic [pspp_pkg::TIME_W-1:0] scr,
                                           input logic [pspp_pkg::MUX_RATE_W-1:0] rate);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h00;
      4'd1:    b = 8'h00;
      4'd2:    b = 8'h01;
      4'd3:    b = 8'hBA;
      4'd4:    b = {2'b01, scr[32:30], 1'b1, scr[29:28]};
      4'd5:    b = scr[27:20];
      4'd6:    b = {scr[19:15], 1'b1, scr[14:13]};
      4'd7:    b = scr[12:5];
      4'd8:    b = {scr[4:0], 3'b100};
      4'd9:    b = 8'h01;
      4'd10:   b = rate[21:14];
      4'd11:   b = rate[13:6];
      4'd12:   b = {rate[5:0], 2'b11};
      4'd13:   b = 8'hF8;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] pes_byte(input logic [3:0] idx, input logic timed,
                                          input pspp_pkg::job_t job);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h00;
      4'd1:    b = 8'h00;
      4'd2:    b = 8'h01;
      4'd3:    b = job.stream;
      4'd4:    b = job.len_field[15:8];
      4'd5:    b = job.len_field[7:0];
      4'd6:    b = 8'h80;
      4'd7:    b = timed ? 8'h80 : 8'h00;
      4'd8:    b = timed ? 8'h05 : 8'h00;
      4'd9:    b = {4'b0010, job.pts[32:30], 1'b1};
      4'd10:   b = job.pts[29:22];
      4'd11:   b = {job.pts[21:15], 1'b1};
      4'd12:   b = job.pts[14:7];
      4'd13:   b = {job.pts[6:0], 1'b1};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  logic [4:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       is_header_q, is_header_d;
  logic       last_q, last_d;

  logic [4:0] hdr_len, job_len, pes_idx;
  logic       advance, load, last_s;

  always_comb begin
    case (job_i.hdr)
      pspp_pkg::HDR_PES:  hdr_len = 5'(pspp_pkg::PES_HDR_SHORT);
      pspp_pkg::HDR_PACK: hdr_len = 5'(pspp_pkg::PES_HDR_LONG) + PackLen;
      default:            hdr_len = 5'd0;
    endcase
  end

  assign job_len   = hdr_len + 5'(job_i.has_data);
  assign advance   = !out_valid_q || pop_i;
  assign load      = advance && job_valid_i;
  assign last_s    = idx_q == job_len - 5'd1;
  assign job_pop_o = load && last_s;
  assign pes_idx   = (job_i.hdr == pspp_pkg::HDR_PACK) ? idx_q - PackLen : idx_q;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    is_header_d = is_header_q;
    last_d      = last_q;
    if (advance) begin
      out_valid_d = job_valid_i;
    end
    if (load) begin
      idx_d       = last_s ? 5'd0 : idx_q + 5'd1;
      last_d      = last_s;
      is_header_d = idx_q < hdr_len;
      if (idx_q >= hdr_len) begin
        out_byte_d = job_i.data;
      end else if (job_i.hdr == pspp_pkg::HDR_PACK && idx_q < PackLen) begin
        out_byte_d = pack_byte(idx_q[3:0], job_i.scr, mux_rate_i);
      end else begin
        out_byte_d = pes_byte(pes_idx[3:0], job_i.hdr == pspp_pkg::HDR_PACK, job_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    is_header_q <= is_header_d;
    last_q      <= last_d;
  end

  assign empty_o     = !out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign is_header_o = is_header_q;
  assign last_o      = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> idx_q < job_len)
    else $error("byte position beyond the end of the job");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> idx_q == 5'd0)
    else $error("byte position not rewound after a finished job");

endmodule
`default_nettype wire

FILE: rtl/program_stream_pes_packetizer_core.sv
// Top level of the MPEG-2 program stream PES packetizer.
// Input items arrive on a queue-like port: an item transfers at a rising edge with push
// high and full low. A start item (command 0) emits a 14-byte pack header and a 14-byte
// PES header with PTS when has_time is set, else a 9-byte PES header. Payload items
// (command 1) pass one byte each; a 9-byte continuation PES header precedes the byte
// that opens a new packet once the previous packet's 65535-byte limit is used up.
// Result bytes leave on a second queue-like port: the oldest byte is shown while empty
// is low and transfers at a rising edge with pop high. Last marks the final byte of an
// item, is_header marks header bytes.
// Items pass the job queue and then the output register. The serializer emits one byte
// per cycle unless stalled, so payload items sustain one per cycle and a start item
// holds it for 9 or 28 header bytes; a queue of JOB_DEPTH jobs lets input continue
// through an output stall, after which full rises and holds input. Reset restores mux
// rate 2621 and PTS delay 27000 and closes any open payload. Configuration writes take
// effect at the next edge and are made while idle by the user; the block does not check.
`default_nettype none
module program_stream_pes_packetizer_core #(
  parameter int unsigned LENGTH_BITS = pspp_pkg::LENGTH_BITS_DEF,
  parameter int unsigned JOB_DEPTH   = pspp_pkg::JOB_DEPTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [pspp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [pspp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic                                command_i,
  input  wire logic [7:0]                          stream_id_i,
  input  wire logic [pspp_pkg::PAYLOAD_LEN_W-1:0]  payload_length_i,
  input  wire logic                                has_time_i,
  input  wire logic [pspp_pkg::TIME_W-1:0]         time_ticks_i,
  input  wire logic [7:0]                          payload_byte_i,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [7:0]                               out_byte_o,
  output logic                                     is_header_o,
  output logic                                     last_o
);

  logic [pspp_pkg::MUX_RATE_W-1:0]  mux_rate_q;
  logic [pspp_pkg::PTS_DELAY_W-1:0] pts_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mux_rate_q  <= pspp_pkg::MUX_RATE_RST;
      pts_delay_q <= pspp_pkg::PTS_DELAY_RST;
    end else if (cfg_we_i) begin
      case (pspp_pkg::cfg_reg_e'(cfg_idx_i))
        pspp_pkg::REG_MUX_RATE:  mux_rate_q  <= cfg_data_i[pspp_pkg::MUX_RATE_W-1:0];
        pspp_pkg::REG_PTS_DELAY: pts_delay_q <= cfg_data_i[pspp_pkg::PTS_DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  pspp_pkg::job_t front_job, fifo_job;
  logic           front_push, fifo_pop, fifo_valid, fifo_full;

  pspp_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (push && !fifo_full),
    .command_i       (command_i),
    .stream_id_i     (stream_id_i),
    .payload_length_i(payload_length_i),
    .has_time_i      (has_time_i),
    .time_ticks_i    (time_ticks_i),
    .payload_byte_i  (payload_byte_i),
    .pts_delay_i     (pts_delay_q),
    .job_o           (front_job),
    .job_push_o      (front_push)
  );

  pspp_job_fifo #(
    .DEPTH(JOB_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (front_push),
    .wr_job_i(front_job),
    .rd_i    (fifo_pop),
    .rd_job_o(fifo_job),
    .full_o  (fifo_full),
    .valid_o (fifo_valid)
  );

  pspp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (fifo_job),
    .job_valid_i(fifo_valid),
    .job_pop_o  (fifo_pop),
    .mux_rate_i (mux_rate_q),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_byte_o (out_byte_o),
    .is_header_o(is_header_o),
    .last_o     (last_o)
  );

  assign full = fifo_full;

endmodule
`default_nettype wire

FILE: tb/sv/program_stream_pes_packetizer_core_tb.sv
// Self-checking testbench for the program stream PES packetizer core.
`default_nettype none
module program_stream_pes_packetizer_core_tb;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  localparam logic [7:0] PACK_START_CODE = 8'hBA;
  localparam logic [7:0] PACK_STUFFING = 8'hF8;
  localparam logic [7:0] PES_MARKER_BITS = 8'h80;
  localparam logic [7:0] PES_PTS_FLAG = 8'h80;
  localparam logic [7:0] PES_PTS_HDR_LEN = 8'd5;

  localparam logic [pspp_pkg::MUX_RATE_W-1:0] MUX_RATE_MAX = '1;
  localparam logic [pspp_pkg::PTS_DELAY_W-1:0] PTS_DELAY_MAX = '1;

  localparam int unsigned PHASE_ITEMS = 85;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES = 12;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       last;
  } ps_byte_t;

  class ps_stream_scoreboard;
    logic [pspp_pkg::MUX_RATE_W-1:0]      mux_rate;
    logic [pspp_pkg::PTS_DELAY_W-1:0]     pts_delay;
    logic [pspp_pkg::LENGTH_BITS_DEF-1:0] payload_left;
    logic [15:0]                          packet_left;
    logic [7:0]                           stream;
    ps_byte_t                             expected_bytes[$];
    int unsigned                          continuations;

    function new();
      mux_rate = pspp_pkg::MUX_RATE_RST;
      pts_delay = pspp_pkg::PTS_DELAY_RST;
      payload_left = '0;
      packet_left = '0;
      stream = '0;
      continuations = 0;
    endfunction

    function void write_reg(pspp_pkg::cfg_reg_e idx, logic [pspp_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        pspp_pkg::REG_MUX_RATE: mux_rate = value[pspp_pkg::MUX_RATE_W-1:0];
        pspp_pkg::REG_PTS_DELAY: pts_delay = value[pspp_pkg::PTS_DELAY_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    function void add_byte(logic [7:0] b, logic hdr);
      ps_byte_t e;
      e.data = b;
      e.hdr = hdr;
      e.last = 1'b0;
      expected_bytes.push_back(e);
    endfunction

    function void add_pack_header(logic [pspp_pkg::TIME_W-1:0] scr);
      add_byte(8'h00, 1'b1);
      add_byte(8'h00, 1'b1);
      add_byte(8'h01, 1'b1);
      add_byte(PACK_START_CODE, 1'b1);
      add_byte({2'b01, scr[32:30], 1'b1, scr[29:28]}, 1'b1);
      add_byte(scr[27:20], 1'b1);
      add_byte({scr[19:15], 1'b1, scr[14:13]}, 1'b1);
      add_byte(scr[12:5], 1'b1);
      add_byte({scr[4:0], 3'b100}, 1'b1);
      add_byte(8'h01, 1'b1);
      add_byte(mux_rate[21:14], 1'b1);
      add_byte(mux_rate[13:6], 1'b1);
      add_byte({mux_rate[5:0], 2'b11}, 1'b1);
      add_byte(PACK_STUFFING, 1'b1);
    endfunction

    function void add_pes_header(logic with_pts, logic [pspp_pkg::TIME_W-1:0] pts);
      int unsigned hdr_len;
      int unsigned total;
      logic [15:0] len_field;
      hdr_len = with_pts ? pspp_pkg::PES_HDR_LONG : pspp_pkg::PES_HDR_SHORT;
      total = payload_left + hdr_len;
      if (total > pspp_pkg::PES_MAX) begin
        total = pspp_pkg::PES_MAX;
      end
      packet_left = 16'(total - hdr_len);
      len_field = 16'(total - pspp_pkg::PES_LEN_OFS);
      add_byte(8'h00, 1'b1);
      add_byte(8'h00, 1'b1);
      add_byte(8'h01, 1'b1);
      add_byte(stream, 1'b1);
      add_byte(len_field[15:8], 1'b1);
      add_byte(len_field[7:0], 1'b1);
      add_byte(PES_MARKER_BITS, 1'b1);
      if (with_pts) begin
        add_byte(PES_PTS_FLAG, 1'b1);
        add_byte(PES_PTS_HDR_LEN, 1'b1);
        add_byte({4'b0010, pts[32:30], 1'b1}, 1'b1);
        add_byte(pts[29:22], 1'b1);
        add_byte({pts[21:15], 1'b1}, 1'b1);
        add_byte(pts[14:7], 1'b1);
        add_byte({pts[6:0], 1'b1}, 1'b1);
      end else begin
        add_byte(8'h00, 1'b1);
        add_byte(8'h00, 1'b1);
      end
    endfunction

    // Returns the number of bytes the item produces; zero means it was ignored.
    function int unsigned accept_item(logic cmd, logic [7:0] sid, logic [23:0] len,
                                      logic ht, logic [pspp_pkg::TIME_W-1:0] ticks,
                                      logic [7:0] data);
      int unsigned before_size;
      logic [pspp_pkg::TIME_W-1:0] pts;
      ps_byte_t tail;
      before_size = expected_bytes.size();
      if (cmd == CMD_START) begin
        stream = sid;
        payload_left = len;
        if (ht) begin
          add_pack_header(ticks);
        end
        pts = ticks + {{(pspp_pkg::TIME_W-pspp_pkg::PTS_DELAY_W){1'b0}}, pts_delay};
        add_pes_header(ht, pts);
      end else if (payload_left != 0) begin
        if (packet_left == 0) begin
          add_pes_header(1'b0, '0);
          continuations++;
        end
        add_byte(data, 1'b0);
        payload_left--;
        if (packet_left > 0) begin
          packet_left--;
        end
      end
      if (expected_bytes.size() > before_size) begin
        tail = expected_bytes.pop_back();
        tail.last = 1'b1;
        expected_bytes.push_back(tail);
      end
      return expected_bytes.size() - before_size;
    endfunction

    function bit check_byte(logic [7:0] data, logic hdr, logic last, output string msg);
      ps_byte_t want;
      msg = "";
      if (expected_bytes.size() == 0) begin
        msg = $sformatf("unexpected byte %h is_header %b last %b", data, hdr, last);
        return 1'b0;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data) begin
        msg = {msg, $sformatf(" out_byte %h want %h", data, want.data)};
      end
      if (hdr !== want.hdr) begin
        msg = {msg, $sformatf(" is_header %b want %b", hdr, want.hdr)};
      end
      if (last !== want.last) begin
        msg = {msg, $sformatf(" last %b want %b", last, want.last)};
      end
      return msg == "";
    endfunction
  endclass

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               cfg_we_i = 1'b0;
  logic [pspp_pkg::CFG_IDX_W-1:0]     cfg_idx_i = '0;
  logic [pspp_pkg::CFG_DATA_W-1:0]    cfg_data_i = '0;
  logic                               push = 1'b0;
  logic                               full;
  logic                               command_i = 1'b0;
  logic [7:0]                         stream_id_i = '0;
  logic [pspp_pkg::PAYLOAD_LEN_W-1:0] payload_length_i = '0;
  logic                               has_time_i = 1'b0;
  logic [pspp_pkg::TIME_W-1:0]        time_ticks_i = '0;
  logic [7:0]                         payload_byte_i = '0;
  logic                               empty;
  logic                               pop = 1'b0;
  logic [7:0]                         out_byte_o;
  logic                               is_header_o;
  logic                               last_o;

  ps_stream_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_pending = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned items_accepted = 0;
  int unsigned items_ignored = 0;
  int unsigned bytes_checked = 0;
  int unsigned header_bytes = 0;
  int unsigned quiet_cycles = 0;

  program_stream_pes_packetizer_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .command_i        (command_i),
    .stream_id_i      (stream_id_i),
    .payload_length_i (payload_length_i),
    .has_time_i       (has_time_i),
    .time_ticks_i     (time_ticks_i),
    .payload_byte_i   (payload_byte_i),
    .empty            (empty),
    .pop              (pop),
    .out_byte_o       (out_byte_o),
    .is_header_o      (is_header_o),
    .last_o           (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch at %0t:%s", $time, what);
    end
  endtask

  function automatic logic [pspp_pkg::TIME_W-1:0] rand_ticks();
    return {($urandom_range(1, 0) == 1), $urandom()};
  endfunction

  // Push stays high after a transfer so back-to-back items need no second assignment.
  task automatic send_item(logic cmd, logic [7:0] sid, logic [23:0] len, logic ht,
                           logic [pspp_pkg::TIME_W-1:0] ticks, logic [7:0] data);
    int unsigned produced;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    command_i <= cmd;
    stream_id_i <= sid;
    payload_length_i <= len;
    has_time_i <= ht;
    time_ticks_i <= ticks;
    payload_byte_i <= data;
    do @(posedge clk_i); while (full);
    produced = sb.accept_item(cmd, sid, len, ht, ticks, data);
    items_accepted++;
    if (produced == 0) begin
      items_ignored++;
    end
  endtask

  task automatic send_start(logic [7:0] sid, logic [23:0] len, logic ht,
                            logic [pspp_pkg::TIME_W-1:0] ticks);
    send_item(CMD_START, sid, len, ht, ticks, 8'($urandom()));
  endtask

  task automatic send_payload(logic [7:0] data);
    send_item(CMD_PAYLOAD, 8'($urandom()), 24'($urandom()), ($urandom_range(1, 0) == 1),
              rand_ticks(), data);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(logic [pspp_pkg::MUX_RATE_W-1:0] rate,
                              logic [pspp_pkg::PTS_DELAY_W-1:0] delay);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= pspp_pkg::REG_MUX_RATE;
    cfg_data_i <= pspp_pkg::CFG_DATA_W'(rate);
    @(posedge clk_i);
    sb.write_reg(pspp_pkg::REG_MUX_RATE, pspp_pkg::CFG_DATA_W'(rate));
    cfg_idx_i <= pspp_pkg::REG_PTS_DELAY;
    cfg_data_i <= pspp_pkg::CFG_DATA_W'(delay);
    @(posedge clk_i);
    sb.write_reg(pspp_pkg::REG_PTS_DELAY, pspp_pkg::CFG_DATA_W'(delay));
    cfg_we_i <= 1'b0;
  endtask

  // Mostly complete packets; some are cut short by the next start or overrun.
  task automatic send_random_packet();
    int unsigned pick;
    int unsigned follow;
    logic [23:0] len;
    pick = $urandom_range(99, 0);
    if (pick < 10) begin
      len = 24'($urandom());
    end else if (pick < 20) begin
      len = 24'($urandom_range(40, 13));
    end else begin
      len = 24'($urandom_range(12, 0));
    end
    send_start(8'($urandom()), len, ($urandom_range(1, 0) == 1), rand_ticks());
    pick = $urandom_range(99, 0);
    if (len > 60) begin
      follow = $urandom_range(20, 0);
    end else if (pick < 80) begin
      follow = len;
    end else if (pick < 90) begin
      follow = $urandom_range(len, 0);
    end else begin
      follow = len + $urandom_range(3, 1);
    end
    repeat (follow) send_payload(8'($urandom()));
  endtask

  task automatic run_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                  int unsigned count);
    int unsigned goal;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    goal = items_accepted - items_ignored + count;
    while (items_accepted - items_ignored < goal) begin
      if ($urandom_range(99, 0) < 15) begin
        send_payload(8'($urandom()));
      end else begin
        send_random_packet();
      end
    end
  endtask

  initial begin : result_sink
    string msg;
    @(posedge rst_ni);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        pop <= ($urandom_range(99, 0) >= recv_stall_pct);
        @(posedge clk_i);
        if (pop && !empty) begin
          bytes_checked++;
          if (is_header_o) begin
            header_bytes++;
          end
          if (!sb.check_byte(out_byte_o, is_header_o, last_o, msg)) begin
            report_mismatch(msg);
          end
        end
      end
    end
  end

  initial begin : watchdog
    @(posedge rst_ni);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_payload(8'h5A);
    send_start(8'hE0, 24'd0, 1'b0, rand_ticks());
    send_payload(8'h11);
    send_start(8'hC0, 24'd3, 1'b1, '0);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'hA5);
    send_payload(8'h3C);
    send_start(8'hFF, '1, 1'b0, '1);
    send_payload(8'h01);
    send_start(8'h00, 24'd2, 1'b1, '1);
    send_payload(8'h7E);
    send_payload(8'h81);
    settle();
    write_config(MUX_RATE_MAX, PTS_DELAY_MAX);
    send_start(8'hBD, 24'd1, 1'b1, 33'h1_5555_5555);
    send_payload(8'h80);
    send_start(8'hE1, 24'h00FFF0, 1'b1, '1);
    send_payload(8'h55);
    settle();
    write_config('0, '0);
    send_start(8'hC1, 24'd0, 1'b1, 33'h0_AAAA_AAAA);
    send_payload(8'hC3);

    settle();
    write_config(22'($urandom()), 20'($urandom()));
    hold_pending = 1'b1;
    send_start(8'($urandom()), 24'd40, 1'b1, rand_ticks());
    repeat (40) send_payload(8'($urandom()));
    settle();
    run_random_phase(0, 0, PHASE_ITEMS);

    settle();
    write_config(MUX_RATE_MAX, '0);
    run_random_phase(75, 0, PHASE_ITEMS);

    settle();
    write_config('0, PTS_DELAY_MAX);
    run_random_phase(0, 75, PHASE_ITEMS);

    settle();
    write_config(22'($urandom()), 20'($urandom()));
    run_random_phase(38, 38, PHASE_ITEMS);

    recv_stall_pct = 0;
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      report_mismatch($sformatf(" %0d expected bytes never arrived", sb.pending()));
    end

    $display("covered %0d items (%0d ignored payload items), %0d bytes checked",
             items_accepted, items_ignored, bytes_checked);
    $display("%0d header bytes, %0d continuation headers, four idling mixes, one hold-off",
             header_bytes, sb.continuations);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: program_stream_pes_packetizer_core.f
rtl/pspp_pkg.sv
rtl/pspp_front.sv
rtl/pspp_job_fifo.sv
rtl/pspp_back.sv
rtl/program_stream_pes_packetizer_core.sv
tb/sv/program_stream_pes_packetizer_core_tb.sv
